### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the posting scorer RTL, clocked on aclk with
// the synchronous active-low reset aresetn.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of aclk outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property at every rising edge of aclk, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### rtl/bm25f_pkg.sv
// ----------------------------------------------------------------------------
// bm25f_pkg
// Shared constants and types of the BM25F posting scorer.
// ----------------------------------------------------------------------------
package bm25f_pkg;

    localparam int NUM_FIELDS = 4;

    // quotient bits of the per-field term division
    localparam int TQ_BITS    = 40;
    // quotient bits of the saturation ratio division
    localparam int RQ_BITS    = 21;
    // products, normaliser, setup, one stage per quotient bit
    localparam int LANE_DEPTH = 3 + TQ_BITS;
    // lane, sum, ratio setup, ratio bits, idf product, score
    localparam int PIPE_DEPTH = LANE_DEPTH + 2 + RQ_BITS + 2;

    localparam logic [39:0] FMAX    = 40'hFF_FFFF_FFFF;
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    typedef enum logic [2:0] {
        REG_AVG_LEN = 3'd0,
        REG_WEIGHT  = 3'd1,
        REG_IDF     = 3'd2,
        REG_K1      = 3'd3,
        REG_B       = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [39:0] term;
        logic        zero_norm;
    } lane_out_t;

endpackage

### rtl/bm25f_posting_scorer_core.sv
// Streaming BM25F scorer: one posting in, one Q16.16 score out, one posting
// per clock while the skid word is empty. Four parallel field lanes each run
// a 40-stage restoring divider (one quotient bit per stage) after two
// multiply stages and a setup stage. The lanes feed a sum stage, a ratio
// setup stage, a 21-stage ratio divider, an idf multiply and a score stage.
// When the result side stalls, a skid word catches the word leaving the
// pipe. The pipe and the input then hold until the output word is taken.
// Configuration is to be written through the cfg port only while the pipe
// is empty; the block itself does not enforce this.
// ----------------------------------------------------------------------------
// bm25f_posting_scorer_core
// Top level: config registers, field lanes, sum and ratio division,
// output register with skid word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bm25f_posting_scorer_core import bm25f_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_node_id_high,
    input  logic [63:0] s_node_id_low,
    input  logic [15:0] s_tf_field0,
    input  logic [15:0] s_tf_field1,
    input  logic [15:0] s_tf_field2,
    input  logic [15:0] s_tf_field3,
    input  logic [19:0] s_doc_len_field0,
    input  logic [19:0] s_doc_len_field1,
    input  logic [19:0] s_doc_len_field2,
    input  logic [19:0] s_doc_len_field3,
    input  logic        s_last_posting,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_out_node_id_high,
    output logic [63:0] m_out_node_id_low,
    output logic [31:0] m_score,
    output logic        m_out_last
);

    localparam int A_IDX = LANE_DEPTH;
    localparam int C_IDX = LANE_DEPTH + 2 + RQ_BITS;

    logic [63:0] avg_len_reg;
    logic [63:0] weight_reg;
    logic [23:0] idf_reg;
    logic [15:0] k1_reg;
    logic [16:0] b_reg;
    logic [16:0] b_clamp;

    logic        en;
    logic        vld_reg [0:PIPE_DEPTH-1];
    logic [128:0] tag_reg [0:PIPE_DEPTH-1];

    logic [15:0] tf_in  [0:NUM_FIELDS-1];
    logic [19:0] len_in [0:NUM_FIELDS-1];
    lane_out_t   lane_res [0:NUM_FIELDS-1];

    logic [39:0] f_reg;
    logic        zn_a_reg;

    logic [19:0] k1q;
    logic [20:0] kp;
    logic [60:0] num_c;

    logic [40:0]        rrem_reg [0:RQ_BITS];
    logic [RQ_BITS-1:0] rq_reg   [0:RQ_BITS];
    logic [RQ_BITS-1:0] rdvd_reg [0:RQ_BITS];
    logic [40:0]        rden_reg [0:RQ_BITS];
    logic               rzn_reg  [0:RQ_BITS];
    logic               rfz_reg  [0:RQ_BITS];
    logic [40:0]        rrem_next [0:RQ_BITS-1];
    logic               rbit      [0:RQ_BITS-1];

    logic [44:0] prod_reg;
    logic        zn_c_reg;
    logic        fz_c_reg;
    logic [31:0] score_reg;

    logic        leaving;
    logic        m_valid_reg;
    logic        skid_valid_reg;
    logic [128:0] m_tag_reg;
    logic [31:0] m_score_reg;
    logic [128:0] skid_tag_reg;
    logic [31:0] skid_score_reg;

    // configuration
    assign cfg_ready = 1'b1;
    assign b_clamp   = (b_reg > ONE_Q16) ? ONE_Q16 : b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_len_reg <= '0;
            weight_reg  <= '0;
            idf_reg     <= '0;
            k1_reg      <= 16'd4915;
            b_reg       <= 17'd49152;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_AVG_LEN: avg_len_reg <= cfg_wdata;
                REG_WEIGHT:  weight_reg  <= cfg_wdata;
                REG_IDF:     idf_reg     <= cfg_wdata[23:0];
                REG_K1:      k1_reg      <= cfg_wdata[15:0];
                REG_B:       b_reg       <= cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    // the whole pipe advances unless the skid word is occupied
    assign en      = !skid_valid_reg;
    assign s_ready = en;

    always_comb begin
        tf_in[0]  = s_tf_field0;
        tf_in[1]  = s_tf_field1;
        tf_in[2]  = s_tf_field2;
        tf_in[3]  = s_tf_field3;
        len_in[0] = s_doc_len_field0;
        len_in[1] = s_doc_len_field1;
        len_in[2] = s_doc_len_field2;
        len_in[3] = s_doc_len_field3;
    end

    for (genvar i = 0; i < NUM_FIELDS; i++) begin : g_lane
        bm25f_field_lane u_lane (
            .aclk     (aclk),
            .en       (en),
            .weight   (weight_reg[16*i +: 16]),
            .avg_len  (avg_len_reg[16*i +: 16]),
            .b_clamp  (b_clamp),
            .tf       (tf_in[i]),
            .doc_len  (len_in[i]),
            .lane_out (lane_res[i])
        );
    end

    // valid bits and pass-through tag travel alongside the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < PIPE_DEPTH; j++) begin
                vld_reg[j] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int j = 1; j < PIPE_DEPTH; j++) begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg[0] <= {s_last_posting, s_node_id_high, s_node_id_low};
            for (int j = 1; j < PIPE_DEPTH; j++) begin
                tag_reg[j] <= tag_reg[j-1];
            end
        end
    end

    // ratio division: f*(k1+1)/(f+k1), one quotient bit per stage
    assign k1q   = {k1_reg, 4'b0};
    assign kp    = 21'(k1q) + 21'(ONE_Q16);
    assign num_c = 61'(f_reg) * 61'(kp);

    always_comb begin
        logic [41:0] trial;
        for (int k = 0; k < RQ_BITS; k++) begin
            trial = {rrem_reg[k], rdvd_reg[k][RQ_BITS-1]};
            if (trial >= {1'b0, rden_reg[k]}) begin
                rrem_next[k] = 41'(trial - {1'b0, rden_reg[k]});
                rbit[k]      = 1'b1;
            end else begin
                rrem_next[k] = trial[40:0];
                rbit[k]      = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        logic [41:0] sum;
        logic        zn;
        if (en) begin
            sum = '0;
            zn  = 1'b0;
            for (int i = 0; i < NUM_FIELDS; i++) begin
                sum = sum + 42'(lane_res[i].term);
                zn  = zn | lane_res[i].zero_norm;
            end
            zn_a_reg <= zn;
            f_reg <= (sum > 42'(FMAX)) ? FMAX : sum[39:0];

            rrem_reg[0] <= {1'b0, num_c[60:RQ_BITS]};
            rdvd_reg[0] <= num_c[RQ_BITS-1:0];
            rden_reg[0] <= 41'(f_reg) + 41'(k1q);
            rq_reg[0]   <= '0;
            rzn_reg[0]  <= zn_a_reg;
            rfz_reg[0]  <= (f_reg == '0);

            for (int k = 0; k < RQ_BITS; k++) begin
                rrem_reg[k+1] <= rrem_next[k];
                rdvd_reg[k+1] <= {rdvd_reg[k][RQ_BITS-2:0], 1'b0};
                rden_reg[k+1] <= rden_reg[k];
                rq_reg[k+1]   <= {rq_reg[k][RQ_BITS-2:0], rbit[k]};
                rzn_reg[k+1]  <= rzn_reg[k];
                rfz_reg[k+1]  <= rfz_reg[k];
            end

            prod_reg <= 45'(idf_reg) * 45'(rq_reg[RQ_BITS]);
            zn_c_reg <= rzn_reg[RQ_BITS];
            fz_c_reg <= rfz_reg[RQ_BITS];

            if (zn_c_reg) begin
                score_reg <= '1;
            end else if (fz_c_reg) begin
                score_reg <= '0;
            end else begin
                score_reg <= {3'b0, prod_reg[44:16]};
            end
        end
    end

    // output register and skid word
    assign leaving = en && vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= leaving;
            end
        end else if (leaving) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_tag_reg   <= skid_tag_reg;
                m_score_reg <= skid_score_reg;
            end else begin
                m_tag_reg   <= tag_reg[PIPE_DEPTH-1];
                m_score_reg <= score_reg;
            end
        end else if (leaving) begin
            skid_tag_reg   <= tag_reg[PIPE_DEPTH-1];
            skid_score_reg <= score_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_out_last         = m_tag_reg[128];
    assign m_out_node_id_high = m_tag_reg[127:64];
    assign m_out_node_id_low  = m_tag_reg[63:0];
    assign m_score            = m_score_reg;

    // skid word is only used behind a held output word
    `ASSERT_CLK(a_skid_behind_out, skid_valid_reg |-> m_valid_reg, "skid word without output word")
    // skid fills only when a word leaves the pipe into a stalled output
    `ASSERT_CLK(a_skid_fill, $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_ready && leaving), "skid filled without stall")
    // a stalled output with a word leaving the pipe must catch it
    `ASSERT_CLK(a_skid_catch, (m_valid_reg && !m_ready && leaving) |=> skid_valid_reg, "word dropped at output stall")
    // the sum stage index A_IDX lies before C_IDX, and C_IDX lies inside the pipe
    `ASSERT_ALWAYS(a_depth, (A_IDX < C_IDX) && (C_IDX < PIPE_DEPTH), "pipeline index layout broken")

endmodule

### rtl/bm25f_field_lane.sv
// ----------------------------------------------------------------------------
// bm25f_field_lane
// One field of the score: weight*tf*avg over the length normaliser,
// as a pipelined restoring divider with one quotient bit per stage.
// ----------------------------------------------------------------------------
module bm25f_field_lane import bm25f_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [15:0] weight,
    input  logic [15:0] avg_len,
    input  logic [16:0] b_clamp,
    input  logic [15:0] tf,
    input  logic [19:0] doc_len,
    output lane_out_t   lane_out
);

    logic [31:0] wtf_reg;
    logic [15:0] avg1_reg;
    logic [32:0] ob_reg;
    logic [36:0] blen_reg;
    logic        cnt1_reg;

    logic [47:0] p_reg;
    logic [40:0] d_reg;
    logic        cnt2_reg;

    logic [40:0]        rem_reg [0:TQ_BITS];
    logic [TQ_BITS-1:0] q_reg   [0:TQ_BITS];
    logic [19:0]        dvd_reg [0:TQ_BITS];
    logic [40:0]        dv_reg  [0:TQ_BITS];
    logic               ovf_reg [0:TQ_BITS];
    logic               dz_reg  [0:TQ_BITS];
    logic               cnt_reg [0:TQ_BITS];

    logic [40:0] rem_next [0:TQ_BITS-1];
    logic        qbit     [0:TQ_BITS-1];

    always_comb begin
        logic [41:0] trial;
        for (int k = 0; k < TQ_BITS; k++) begin
            trial = {rem_reg[k], dvd_reg[k][19]};
            if (trial >= {1'b0, dv_reg[k]}) begin
                rem_next[k] = 41'(trial - {1'b0, dv_reg[k]});
                qbit[k]     = 1'b1;
            end else begin
                rem_next[k] = trial[40:0];
                qbit[k]     = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            wtf_reg  <= weight * tf;
            avg1_reg <= avg_len;
            ob_reg   <= 33'(ONE_Q16 - b_clamp) * 33'(avg_len);
            blen_reg <= 37'(b_clamp) * 37'(doc_len);
            cnt1_reg <= (weight != '0) && (avg_len != '0) && (tf != '0);

            p_reg    <= 48'(wtf_reg) * 48'(avg1_reg);
            d_reg    <= 41'(ob_reg) + {blen_reg, 4'b0};
            cnt2_reg <= cnt1_reg;

            // overflow when the quotient needs more than TQ_BITS bits
            rem_reg[0] <= {13'b0, p_reg[47:20]};
            dvd_reg[0] <= p_reg[19:0];
            dv_reg[0]  <= d_reg;
            q_reg[0]   <= '0;
            ovf_reg[0] <= {13'b0, p_reg} >= {d_reg, 20'b0};
            dz_reg[0]  <= (d_reg == '0);
            cnt_reg[0] <= cnt2_reg;

            for (int k = 0; k < TQ_BITS; k++) begin
                rem_reg[k+1] <= rem_next[k];
                dvd_reg[k+1] <= {dvd_reg[k][18:0], 1'b0};
                dv_reg[k+1]  <= dv_reg[k];
                q_reg[k+1]   <= {q_reg[k][TQ_BITS-2:0], qbit[k]};
                ovf_reg[k+1] <= ovf_reg[k];
                dz_reg[k+1]  <= dz_reg[k];
                cnt_reg[k+1] <= cnt_reg[k];
            end
        end
    end

    always_comb begin
        lane_out.zero_norm = cnt_reg[TQ_BITS] && dz_reg[TQ_BITS];
        if (!cnt_reg[TQ_BITS] || dz_reg[TQ_BITS]) begin
            lane_out.term = '0;
        end else if (ovf_reg[TQ_BITS]) begin
            lane_out.term = FMAX;
        end else begin
            lane_out.term = q_reg[TQ_BITS];
        end
    end

endmodule
